/* rtl/core/sips_pkg.sv */
// Package for the sorted insert position search block.
// Holds the operation codes and the control word passed along the cell chain.
// No dependencies.
package sips_pkg;

  typedef logic [1:0] func_t;

  localparam func_t FUNC_APPEND = 2'd0;
  localparam func_t FUNC_QUERY  = 2'd1;
  localparam func_t FUNC_CLEAR  = 2'd2;

  typedef struct packed {
    logic  valid;
    func_t func;
    logic  done;
  } sips_ctl_t;

endpackage

/* rtl/core/sips_if.sv */
// Channel interfaces for the sorted insert position search block.
// Input word: operation, entry value, target value. Result word: insert position.
// Depends on sips_pkg.
interface sips_in_if #(
  parameter int DW = 32
);
  logic                 valid;
  logic                 ready;
  sips_pkg::func_t      func;
  logic signed [DW-1:0] entry_value;
  logic signed [DW-1:0] target_value;

  modport source (output valid, output func, output entry_value, output target_value,
                  input ready);
  modport sink (input valid, input func, input entry_value, input target_value,
                output ready);
endinterface

interface sips_out_if #(
  parameter int PW = 7
);
  logic          valid;
  logic          ready;
  logic [PW-1:0] insert_position;

  modport source (output valid, output insert_position, input ready);
  modport sink (input valid, input insert_position, output ready);
endinterface

/* rtl/core/sips_cell.sv */
// One cell of the search chain: holds one table entry and its used flag.
// Applies the passing word to its entry and hands the word to the next cell.
// Depends on sips_pkg.
module sips_cell #(
  parameter int DW    = 32,
  parameter int PW    = 7,
  parameter int INDEX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  sips_pkg::sips_ctl_t  ctl_i,
  input  logic signed [DW-1:0] val_i,
  input  logic [PW-1:0]        pos_i,
  output sips_pkg::sips_ctl_t  ctl_o,
  output logic signed [DW-1:0] val_o,
  output logic [PW-1:0]        pos_o
);
  import sips_pkg::*;

  sips_ctl_t            ctl_r, ctl_nxt;
  logic signed [DW-1:0] val_r;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic signed [DW-1:0] entry_r, entry_nxt;
  logic                 used_r, used_nxt;

  always_comb begin
    ctl_nxt   = ctl_i;
    pos_nxt   = pos_i;
    entry_nxt = entry_r;
    used_nxt  = used_r;
    if (ctl_i.valid) begin
      case (ctl_i.func)
        FUNC_APPEND: begin
          if (!ctl_i.done && !used_r) begin
            entry_nxt    = val_i;
            used_nxt     = 1'b1;
            ctl_nxt.done = 1'b1;
          end
        end
        FUNC_CLEAR: begin
          used_nxt = 1'b0;
        end
        FUNC_QUERY: begin
          if (!ctl_i.done && (!used_r || entry_r >= val_i)) begin
            ctl_nxt.done = 1'b1;
            pos_nxt      = PW'(INDEX);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r  <= '0;
      used_r <= 1'b0;
    end else if (adv) begin
      ctl_r  <= ctl_nxt;
      used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val_r   <= val_i;
      pos_r   <= pos_nxt;
      entry_r <= entry_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign val_o = val_r;
  assign pos_o = pos_r;

endmodule

/* rtl/core/sorted_insert_position_search.sv */
// Channel   Dir  Word
// in_ch     in   func, entry_value, target_value
// out_ch    out  insert_position (queries only)
// Every word walks the chain of DEPTH cells, one cell per cycle while the chain advances, then the output register.
// A word is accepted every cycle while the chain advances; a query result leaves from the output register.
// The chain advances as a whole: it stops while a result is held and not taken.
// Reset clears all used flags and the chain's valid bits; entries are not cleared.
// Top level of the sorted insert position search. Depends on sips_pkg, sips_if, sips_cell.
module sorted_insert_position_search #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input logic        clk,
  input logic        rst_n,
  sips_in_if.sink    in_ch,
  sips_out_if.source out_ch
);
  import sips_pkg::*;

  localparam int PW = $clog2(DEPTH + 1);

  sips_ctl_t                    ctl_c [0:DEPTH];
  logic signed [DATA_WIDTH-1:0] val_c [0:DEPTH];
  logic [PW-1:0]                pos_c [0:DEPTH];

  logic          adv;
  logic          out_valid_r;
  logic [PW-1:0] out_pos_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  assign ctl_c[0].valid = in_ch.valid;
  assign ctl_c[0].func  = in_ch.func;
  assign ctl_c[0].done  = 1'b0;
  assign val_c[0] = (in_ch.func == FUNC_APPEND) ? in_ch.entry_value : in_ch.target_value;
  assign pos_c[0] = PW'(DEPTH);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sips_cell #(
      .DW    (DATA_WIDTH),
      .PW    (PW),
      .INDEX (i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .ctl_i (ctl_c[i]),
      .val_i (val_c[i]),
      .pos_i (pos_c[i]),
      .ctl_o (ctl_c[i+1]),
      .val_o (val_c[i+1]),
      .pos_o (pos_c[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_c[DEPTH].valid && (ctl_c[DEPTH].func == FUNC_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pos_r <= pos_c[DEPTH];
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.insert_position = out_pos_r;

`ifndef SYNTH
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while result stalled");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pos_r <= PW'(DEPTH))
    else $error("insert position beyond table depth");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r)
    else $error("result present right after reset");
`endif

endmodule

/* tb/tb_top.sv */
// Testbench for sorted_insert_position_search: appends, clears and lower-bound queries
// checked against a table model kept here. Uses sips_pkg, sips_in_if and sips_out_if.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sips_pkg::*;

  localparam int DEPTH        = 64;
  localparam int DATA_WIDTH   = 32;
  localparam int POS_WIDTH    = 7;
  localparam int RANDOM_WORDS = 1700;
  localparam int CYCLE_LIMIT  = 400000;
  localparam func_t FUNC_UNUSED = 2'd3;
  localparam int VAL_MIN = 32'sh8000_0000;
  localparam int VAL_MAX = 32'sh7fff_ffff;

  typedef enum int {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

  typedef struct {
    func_t                        func;
    logic signed [DATA_WIDTH-1:0] entry_value;
    logic signed [DATA_WIDTH-1:0] target_value;
    pace_t                        pace;
    bit                           drain_first;
  } search_word_t;

  logic clk;
  logic rst_n;

  sips_in_if #(.DW(DATA_WIDTH)) in_ch ();
  sips_out_if #(.PW(POS_WIDTH)) out_ch ();

  sorted_insert_position_search #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  search_word_t                 pending_words[$];
  logic [POS_WIDTH-1:0]         expected_positions[$];
  logic signed [DATA_WIDTH-1:0] table_vals[DEPTH];
  int                           table_count = 0;
  search_word_t                 held_word;
  pace_t                        cur_pace = PACE_FREE;
  int                           words_queued = 0;
  int                           words_accepted = 0;
  int                           mismatches = 0;
  int                           cycles = 0;
  bit                           send_ok;

  function automatic int idle_percent(pace_t p, bit sender);
    if (p == PACE_BOTH) return 6;
    if (sender && p == PACE_SEND_IDLE) return 54;
    if (!sender && p == PACE_RECV_STALL) return 54;
    return 0;
  endfunction

  function automatic void push_word(func_t f, int ev, int tv, pace_t p, bit d);
    search_word_t w;
    w.func         = f;
    w.entry_value  = ev;
    w.target_value = tv;
    w.pace         = p;
    w.drain_first  = d;
    pending_words.push_back(w);
    if (f != FUNC_UNUSED) words_queued++;
  endfunction

  function automatic void track_word(search_word_t w);
    int pos;
    case (w.func)
      FUNC_APPEND: begin
        if (table_count < DEPTH) begin
          table_vals[table_count] = w.entry_value;
          table_count++;
        end
      end
      FUNC_CLEAR: begin
        table_count = 0;
      end
      FUNC_QUERY: begin
        pos = table_count;
        for (int i = table_count - 1; i >= 0; i--) begin
          if (table_vals[i] >= w.target_value) pos = i;
        end
        expected_positions.push_back(POS_WIDTH'(pos));
      end
      default: ;
    endcase
  endfunction

  initial begin
    clk                = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.func         = FUNC_CLEAR;
    in_ch.entry_value  = '0;
    in_ch.target_value = '0;
    out_ch.ready       = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // driver: hold the word until accepted, then advance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        track_word(held_word);
        words_accepted++;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        send_ok = pending_words.size() != 0;
        if (send_ok && pending_words[0].drain_first && expected_positions.size() != 0)
          send_ok = 1'b0;
        if (send_ok && $urandom_range(99) < idle_percent(pending_words[0].pace, 1'b1))
          send_ok = 1'b0;
        if (send_ok) begin
          held_word = pending_words.pop_front();
          cur_pace  = held_word.pace;
          in_ch.valid        <= 1'b1;
          in_ch.func         <= held_word.func;
          in_ch.entry_value  <= held_word.entry_value;
          in_ch.target_value <= held_word.target_value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= $urandom_range(99) >= idle_percent(cur_pace, 1'b0);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_positions.size() == 0) begin
        $error("insert_position: expected none, got %0d", out_ch.insert_position);
        mismatches++;
      end else begin
        if (out_ch.insert_position !== expected_positions[0]) begin
          $error("insert_position: expected %0d, got %0d",
                 expected_positions[0], out_ch.insert_position);
          mismatches++;
        end
        void'(expected_positions.pop_front());
      end
    end
  end

  initial begin
    int    vals[$];
    int    n;
    int    nq;
    int    pick;
    int    t;
    int    seq;
    int    base;
    int    total_words;
    bit    narrow;
    pace_t p;

    rst_n = 1'b0;

    push_word(FUNC_QUERY, 0, 0, PACE_FREE, 0);
    push_word(FUNC_QUERY, VAL_MAX, VAL_MIN, PACE_FREE, 0);
    push_word(FUNC_CLEAR, VAL_MIN, VAL_MAX, PACE_FREE, 0);
    push_word(FUNC_APPEND, VAL_MIN, 0, PACE_FREE, 0);
    push_word(FUNC_APPEND, -5, -1, PACE_FREE, 0);
    push_word(FUNC_APPEND, 0, VAL_MAX, PACE_FREE, 0);
    push_word(FUNC_APPEND, 7, VAL_MIN, PACE_FREE, 0);
    push_word(FUNC_APPEND, VAL_MAX, 0, PACE_FREE, 0);
    push_word(FUNC_QUERY, -1, VAL_MIN, PACE_FREE, 0);
    push_word(FUNC_QUERY, 0, -6, PACE_FREE, 0);
    push_word(FUNC_QUERY, 0, -5, PACE_FREE, 0);
    push_word(FUNC_QUERY, 0, -4, PACE_FREE, 0);
    push_word(FUNC_QUERY, 0, 0, PACE_FREE, 0);
    push_word(FUNC_QUERY, 0, 8, PACE_FREE, 0);
    push_word(FUNC_QUERY, VAL_MIN, VAL_MAX, PACE_FREE, 0);
    push_word(FUNC_UNUSED, -1, -1, PACE_FREE, 0);
    push_word(FUNC_QUERY, 0, 7, PACE_FREE, 1);
    push_word(FUNC_CLEAR, 0, 0, PACE_FREE, 0);
    push_word(FUNC_QUERY, 0, 5, PACE_FREE, 0);
    push_word(FUNC_APPEND, 10, 0, PACE_FREE, 0);
    push_word(FUNC_APPEND, 3, 0, PACE_FREE, 0);
    push_word(FUNC_QUERY, 0, 4, PACE_FREE, 0);
    push_word(FUNC_QUERY, 0, 11, PACE_FREE, 0);

    base = words_queued;
    seq  = 0;
    while (words_queued < base + RANDOM_WORDS) begin
      p = pace_t'((seq / 10) % 4);
      if ($urandom_range(9) != 0)
        push_word(FUNC_CLEAR, $urandom, $urandom, p, seq % 12 == 11);
      pick = $urandom_range(99);
      n = pick < 80 ? $urandom_range(12) : pick < 95 ? $urandom_range(40, 13) :
          $urandom_range(70, 60);
      narrow = $urandom_range(3) == 0;
      vals.delete();
      repeat (n) vals.push_back(narrow ? int'($urandom_range(40)) - 20 : int'($urandom));
      if ($urandom_range(99) < 85) vals.sort();
      foreach (vals[i]) begin
        push_word(FUNC_APPEND, vals[i], $urandom, p, 0);
        if ($urandom_range(49) == 0) push_word(FUNC_UNUSED, $urandom, $urandom, p, 0);
        if ($urandom_range(19) == 0) push_word(FUNC_QUERY, $urandom, $urandom, p, 0);
      end
      nq = $urandom_range(8, 1);
      repeat (nq) begin
        pick = $urandom_range(5);
        case (pick)
          0: t = $urandom;
          1: t = VAL_MIN;
          2: t = VAL_MAX;
          default: begin
            if (vals.size() != 0) t = vals[$urandom_range(vals.size() - 1)] + (pick - 4);
            else t = $urandom;
          end
        endcase
        push_word(FUNC_QUERY, $urandom, t, p, 0);
      end
      seq++;
    end
    total_words = pending_words.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (words_accepted < total_words) @(posedge clk);
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/sips_pkg.sv
rtl/core/sips_if.sv
rtl/core/sips_cell.sv
rtl/core/sorted_insert_position_search.sv
tb/tb_top.sv
